[hw/rtl/isdg_pkg.sv]
// Shared types and constants for the image split descriptor generator.
package isdg_pkg;

	localparam int ADDR_W        = 32;
	localparam int DIM_W         = 16;
	localparam int DIV_CNT_W     = $clog2(DIM_W);
	localparam int MAX_PARTS_DEF = 64;

	localparam int COUNT_W = 7;
	localparam int ALIGN_W = 13;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_SCAN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPLIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALIGN = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIM_W-1:0] dividend;
		logic [DIM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] quotient;
		logic [DIM_W-1:0] remainder;
	} div_rsp_t;

endpackage

[hw/rtl/isdg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module isdg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  isdg_pkg::div_req_t req,
	output isdg_pkg::div_rsp_t rsp
);
	import isdg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W-1:0]     quo_q;
	logic [DIM_W-1:0]     div_q;

	logic [DIM_W:0] shifted;
	logic [DIM_W:0] diff;
	logic           ge;
	logic [DIM_W-1:0] rem_next;

	// The partial remainder stays below the divisor, so the shifted value fits one extra bit.
	assign shifted  = {rem_q, quo_q[DIM_W-1]};
	assign diff     = shifted - {1'b0, div_q};
	assign ge       = shifted >= {1'b0, div_q};
	assign rem_next = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIM_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[hw/rtl/image_split_descriptor_generator.sv]
// Top level of the image split descriptor generator: sequencer, registers and output stage.
//
//   channel   direction  handshake              contents
//   in        to block   in_valid / in_stall    base_addr, src_width, src_height, src_stride
//   out       from block out_valid / out_stall  part_addr, part_width, part_height,
//                                               part_stride, last_part
//   config    to block   APB psel/penable/...   scan_order, split_direction, part_count, alignment
//
// An item is accepted, then makes two passes through the shared serial divider, each ending
// with the quotient handed over, goes through the offset multiply and then yields one
// descriptor per part; a zero alignment skips the second pass.
// Reset clears the registers to their defaults and leaves the sequencer idle; no clearing pass.
// A stalled output holds the current descriptor and pauses the descriptor sequence.
// The input is not taken while a request is in work; a zero part count emits nothing.
module image_split_descriptor_generator #(
	parameter int MAX_PARTS = isdg_pkg::MAX_PARTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [isdg_pkg::ADDR_W-1:0]  base_addr,
	input  logic [isdg_pkg::DIM_W-1:0]   src_width,
	input  logic [isdg_pkg::DIM_W-1:0]   src_height,
	input  logic [isdg_pkg::DIM_W-1:0]   src_stride,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [isdg_pkg::ADDR_W-1:0]  part_addr,
	output logic [isdg_pkg::DIM_W-1:0]   part_width,
	output logic [isdg_pkg::DIM_W-1:0]   part_height,
	output logic [isdg_pkg::DIM_W-1:0]   part_stride,
	output logic                         last_part,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [isdg_pkg::PADDR_W-1:0] paddr,
	input  logic [isdg_pkg::PDATA_W-1:0] pwdata,
	output logic [isdg_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import isdg_pkg::*;

	localparam int CNT_W = $clog2(MAX_PARTS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;
	localparam logic [2:0] ST_DIV2 = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic               cfg_scan_q;
	logic               cfg_split_q;
	logic [COUNT_W-1:0] cfg_count_q;
	logic [ALIGN_W-1:0] cfg_align_q;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] base_q;
	logic [DIM_W-1:0]  w_q;
	logic [DIM_W-1:0]  h_q;
	logic [DIM_W-1:0]  s_q;
	logic [CNT_W-1:0]  n_q;
	logic [DIM_W-1:0]  q1_q;
	logic [DIM_W-1:0]  size_q;
	logic [ADDR_W-1:0] offset_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  idx_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] part_addr_q;
	logic [DIM_W-1:0]  part_width_q;
	logic [DIM_W-1:0]  part_height_q;
	logic [DIM_W-1:0]  part_stride_q;
	logic              last_part_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 in_take;
	logic [CNT_W-1:0]     n_sat;
	logic                 emit_load;
	logic                 is_last;
	logic [DIM_W-1:0]     mul_a;
	logic [ADDR_W-1:0]    prod;

	div_req_t div_req;
	div_rsp_t div_rsp;

	isdg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration port.
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_scan_q  <= 1'b0;
			cfg_split_q <= 1'b0;
			cfg_count_q <= COUNT_W'(1);
			cfg_align_q <= ALIGN_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SCAN:  cfg_scan_q  <= pwdata[0];
				REG_SPLIT: cfg_split_q <= pwdata[0];
				REG_COUNT: cfg_count_q <= pwdata[COUNT_W-1:0];
				REG_ALIGN: cfg_align_q <= pwdata[ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCAN:  prdata = PDATA_W'(cfg_scan_q);
			REG_SPLIT: prdata = PDATA_W'(cfg_split_q);
			REG_COUNT: prdata = PDATA_W'(cfg_count_q);
			REG_ALIGN: prdata = PDATA_W'(cfg_align_q);
			default:   prdata = '0;
		endcase
	end

	// Sequencer control.
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign n_sat    = (32'(cfg_count_q) > 32'(MAX_PARTS)) ? CNT_W'(MAX_PARTS)
	                                                      : CNT_W'(cfg_count_q);

	// The first pass divides the split dimension by the part count, the second divides that
	// quotient by the alignment; its remainder rounds the quotient down to the alignment.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = cfg_split_q ? src_height : src_width;
		div_req.divisor  = DIM_W'(n_sat);
		if (state_q == ST_DIV1) begin
			div_req.dividend = div_rsp.quotient;
			div_req.divisor  = DIM_W'(cfg_align_q);
			div_req.start    = div_rsp.done && (cfg_align_q != '0);
		end else if (in_take) begin
			div_req.start = (n_sat != '0);
		end
	end

	assign mul_a = (cfg_scan_q && cfg_split_q) ? w_q : s_q;
	assign prod  = ADDR_W'(mul_a) * ADDR_W'(size_q);

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign is_last   = (idx_q == n_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			size_q      <= '0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take && (n_sat != '0)) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						if (cfg_align_q == '0) begin
							size_q  <= '0;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIV2;
						end
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						size_q  <= q1_q - div_rsp.remainder;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			base_q <= base_addr;
			w_q    <= src_width;
			h_q    <= src_height;
			s_q    <= src_stride;
			n_q    <= n_sat;
		end
		if ((state_q == ST_DIV1) && div_rsp.done) begin
			q1_q <= div_rsp.quotient;
		end
		if (state_q == ST_MUL) begin
			offset_q <= (!cfg_scan_q && !cfg_split_q) ? ADDR_W'(size_q) : prod;
			addr_q   <= base_q;
			idx_q    <= '0;
		end
		if (emit_load) begin
			part_addr_q   <= addr_q;
			part_width_q  <= cfg_split_q ? w_q : size_q;
			part_height_q <= cfg_split_q ? size_q : h_q;
			part_stride_q <= s_q;
			last_part_q   <= is_last;
			addr_q        <= addr_q + offset_q;
			idx_q         <= idx_q + CNT_W'(1);
		end
	end

	assign out_valid   = out_valid_q;
	assign part_addr   = part_addr_q;
	assign part_width  = part_width_q;
	assign part_height = part_height_q;
	assign part_stride = part_stride_q;
	assign last_part   = last_part_q;

endmodule

[tb/sv/tb_image_split_descriptor_generator.sv]
// Self-checking testbench for the image split descriptor generator.
module tb_image_split_descriptor_generator;
	import isdg_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  stride;
		logic              last;
	} part_desc_t;

	typedef struct {
		bit                 wr_cfg;
		logic               scan;
		logic               split;
		logic [COUNT_W-1:0] count;
		logic [ALIGN_W-1:0] align;
		logic [ADDR_W-1:0]  base;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   stride;
		bit                 typed;
		part_desc_t         want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ADDR_W-1:0]    base_addr = '0;
	logic [DIM_W-1:0]     src_width = '0;
	logic [DIM_W-1:0]     src_height = '0;
	logic [DIM_W-1:0]     src_stride = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ADDR_W-1:0]    part_addr;
	logic [DIM_W-1:0]     part_width;
	logic [DIM_W-1:0]     part_height;
	logic [DIM_W-1:0]     part_stride;
	logic                 last_part;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Shadow copy of the configuration, starting from the reset values.
	logic                 cfg_scan = 1'b0;
	logic                 cfg_split = 1'b0;
	logic [COUNT_W-1:0]   cfg_count = 7'd1;
	logic [ALIGN_W-1:0]   cfg_align = 13'd1;

	part_desc_t           pending_parts[$];
	stim_row_t            stim_rows[$];
	int                   mismatch_count = 0;
	logic                 quiet = 1'b0;
	logic                 hold_on = 1'b0;
	bit                   hold_go = 1'b0;

	image_split_descriptor_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.base_addr  (base_addr),
		.src_width  (src_width),
		.src_height (src_height),
		.src_stride (src_stride),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.part_addr  (part_addr),
		.part_width (part_width),
		.part_height(part_height),
		.part_stride(part_stride),
		.last_part  (last_part),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Works out every sub-image descriptor of one request under the current settings.
	task automatic split_descriptor(input logic [ADDR_W-1:0] b, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] s);
		logic [31:0] dim;
		logic [31:0] size;
		logic [31:0] offset;
		logic [31:0] k;
		logic [31:0] n;
		// Counts above the part limit are cut to the limit; a zero count emits nothing.
		n = (32'(cfg_count) > 32'(MAX_PARTS_DEF)) ? 32'(MAX_PARTS_DEF) : 32'(cfg_count);
		if (n == 0)
			return;
		dim = cfg_split ? 32'(h) : 32'(w);
		if (cfg_align == '0)
			size = '0;
		else
			size = ((dim / n) / 32'(cfg_align)) * 32'(cfg_align);
		size = size & 32'h0000_FFFF;
		if (!cfg_scan)
			offset = cfg_split ? 32'(s) * size : size;
		else
			offset = cfg_split ? 32'(w) * size : size * 32'(s);
		for (k = 0; k < n; k++) begin
			pending_parts.push_back('{
				addr:   b + k * offset,
				width:  cfg_split ? w : size[DIM_W-1:0],
				height: cfg_split ? size[DIM_W-1:0] : h,
				stride: s,
				last:   (k + 1 == n)
			});
		end
	endtask

	task automatic check_part();
		part_desc_t want;
		if (pending_parts.size() == 0) begin
			flag_mismatch($sformatf("part at %h with no request pending", part_addr));
		end else begin
			want = pending_parts.pop_front();
			if (part_addr !== want.addr)
				flag_mismatch($sformatf("part_addr %h, wanted %h", part_addr, want.addr));
			if (part_width !== want.width)
				flag_mismatch($sformatf("part_width %0d, wanted %0d", part_width, want.width));
			if (part_height !== want.height)
				flag_mismatch($sformatf("part_height %0d, wanted %0d", part_height, want.height));
			if (part_stride !== want.stride)
				flag_mismatch($sformatf("part_stride %0d, wanted %0d", part_stride, want.stride));
			if (last_part !== want.last)
				flag_mismatch($sformatf("last_part %b, wanted %b", last_part, want.last));
		end
	endtask

	// Output side: checks each accepted descriptor, then picks the next stall value.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_part();
		out_stall <= hold_on || (!quiet && $urandom_range(0, 99) < 17);
	end

	// A long hold-off on the output so that the block backs up and stalls its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic offer_request(input logic [ADDR_W-1:0] b, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] s);
		if (!quiet && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		base_addr  <= b;
		src_width  <= w;
		src_height <= h;
		src_stride <= s;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_parts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// Read the register straight back.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd !== val)
			flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, val));
	endtask

	task automatic set_config(input logic sc, input logic sp, input logic [COUNT_W-1:0] cnt,
			input logic [ALIGN_W-1:0] aln);
		wait_idle();
		cfg_write(REG_SCAN, PDATA_W'(sc));
		cfg_write(REG_SPLIT, PDATA_W'(sp));
		cfg_write(REG_COUNT, PDATA_W'(cnt));
		cfg_write(REG_ALIGN, PDATA_W'(aln));
		cfg_scan  = sc;
		cfg_split = sp;
		cfg_count = cnt;
		cfg_align = aln;
	endtask

	function automatic stim_row_t mk_row(input int wr, input int sc, input int sp,
			input int cnt, input int aln, input logic [31:0] b, input int w, input int h,
			input int s, input int typed, input logic [31:0] ea, input int ew, input int eh,
			input int es);
		stim_row_t r;
		r.wr_cfg = (wr != 0);
		r.scan   = (sc != 0);
		r.split  = (sp != 0);
		r.count  = COUNT_W'(cnt);
		r.align  = ALIGN_W'(aln);
		r.base   = b;
		r.width  = DIM_W'(w);
		r.height = DIM_W'(h);
		r.stride = DIM_W'(s);
		r.typed  = (typed != 0);
		r.want   = '{addr: ea, width: DIM_W'(ew), height: DIM_W'(eh), stride: DIM_W'(es),
			last: 1'b1};
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return DIM_W'($urandom_range(1, 64));
			default: return DIM_W'($urandom);
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 3))
			0: return 7'd1;
			1: return 7'd64;
			default: return COUNT_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [ALIGN_W-1:0] pick_align();
		case ($urandom_range(0, 3))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'd1 << $urandom_range(0, 12);
			default: return ALIGN_W'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin
		stim_rows.push_back(mk_row(0, 0, 0, 1, 1, 32'h0000_1000, 100, 50, 128,
			1, 32'h0000_1000, 100, 50, 128));
		stim_rows.push_back(mk_row(1, 0, 0, 1, 1, 32'hFFFF_FFFF, 65535, 65535, 65535,
			1, 32'hFFFF_FFFF, 65535, 65535, 65535));
		stim_rows.push_back(mk_row(0, 0, 0, 1, 1, 32'h0, 0, 0, 0, 1, 32'h0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 0, 1, 1, 4096, 32'h8000_0000, 1234, 65535, 77,
			1, 32'h8000_0000, 1234, 61440, 77));
		stim_rows.push_back(mk_row(0, 0, 1, 1, 4096, 32'h10, 500, 4095, 9,
			1, 32'h10, 500, 0, 9));
		stim_rows.push_back(mk_row(1, 0, 0, 64, 1, 32'h1000, 640, 480, 1024, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, 0, 64, 1, 32'hFFFF_FFF0, 65535, 1, 65535,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, 0, 64, 1, 32'h4000, 63, 63, 63, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 0, 64, 1, 32'h0, 6400, 100, 8192, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 1, 0, 64, 1, 32'hFFFF_0000, 65535, 65535, 65535,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 1, 7, 3, 32'h1234_5678, 1920, 1080, 2048,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 1, 1, 7, 3, 32'hFFFF_FFFF, 65535, 65535, 65535,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 0, 1, 5, 16, 32'h2000, 320, 240, 384, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, 1, 5, 16, 32'h2000, 320, 0, 384, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 0, 3, 4096, 32'hDEAD_0000, 65535, 10, 100,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 0, 0, 2, 1, 32'h100, 1, 1, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(0, 0, 0, 2, 1, 32'hABCD_EF01, 65535, 0, 0, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 1, 64, 4096, 32'h5555_5555, 65535, 65535, 65535,
			0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(1, 1, 1, 1, 1, 32'h0000_0001, 65535, 65535, 65535,
			1, 32'h0000_0001, 65535, 65535, 65535));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].wr_cfg)
				set_config(stim_rows[r].scan, stim_rows[r].split, stim_rows[r].count,
					stim_rows[r].align);
			offer_request(stim_rows[r].base, stim_rows[r].width, stim_rows[r].height,
				stim_rows[r].stride);
			if (stim_rows[r].typed)
				pending_parts.push_back(stim_rows[r].want);
			else
				split_descriptor(stim_rows[r].base, stim_rows[r].width, stim_rows[r].height,
					stim_rows[r].stride);
		end

		// Random phases: each one a fresh setting followed by a burst of items.
		for (int phase = 0; phase < 7; phase++) begin
			logic [ADDR_W-1:0] b;
			logic [DIM_W-1:0]  w;
			logic [DIM_W-1:0]  h;
			logic [DIM_W-1:0]  s;
			set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_count(),
				pick_align());
			quiet <= (phase == 2);
			if (phase == 4)
				hold_go = 1'b1;
			for (int n = 0; n < 15; n++) begin
				b = $urandom;
				w = pick_dim();
				h = pick_dim();
				s = pick_dim();
				offer_request(b, w, h, s);
				split_descriptor(b, w, h, s);
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
